// ----- rtl/sgwl_pkg.sv -----
package sgwl_pkg;

    localparam int ADDR_BITS       = 48;
    localparam int LINE_BYTES_LOG2 = 6;
    localparam int LINE_BITS       = ADDR_BITS - LINE_BYTES_LOG2;
    localparam int COUNT_BITS      = LINE_BITS + 1;
    localparam int INTERVAL_BITS   = 32;
    localparam int TOTAL_BITS      = 48;
    localparam int CFG_DATA_BITS   = COUNT_BITS;
    localparam int CFG_IDX_BITS    = 1;
    localparam int OP_BITS         = 2;

    typedef logic [OP_BITS-1:0]       op_t;
    typedef logic [ADDR_BITS-1:0]     addr_t;
    typedef logic [LINE_BITS-1:0]     line_t;
    typedef logic [COUNT_BITS-1:0]    count_t;
    typedef logic [INTERVAL_BITS-1:0] interval_t;
    typedef logic [TOTAL_BITS-1:0]    total_t;
    typedef logic [CFG_IDX_BITS-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

    localparam op_t OP_FWD   = 2'd0;
    localparam op_t OP_REV   = 2'd1;
    localparam op_t OP_WRITE = 2'd2;

    localparam cfg_idx_t REG_LINE_COUNT    = 1'd0;
    localparam cfg_idx_t REG_MOVE_INTERVAL = 1'd1;

    localparam count_t    LINES_MIN      = COUNT_BITS'(2);
    localparam count_t    LINES_MAX      = count_t'(1) << LINE_BITS;
    localparam count_t    LINES_RESET    = LINES_MIN;
    localparam interval_t INTERVAL_RESET = INTERVAL_BITS'(100);

    // mapping state seen by the translate logic
    typedef struct packed {
        count_t line_count;
        line_t  n;
        line_t  start;
        line_t  gap;
    } map_state_t;

    typedef struct packed {
        logic out_of_region;
        logic boundary_alias;
        logic gap_hit;
    } xlate_flags_t;

    typedef struct packed {
        total_t moves;
        total_t writes;
        total_t outside;
        total_t aliased;
    } totals_t;

    function automatic total_t sat_inc(input total_t v);
        return (&v) ? v : v + total_t'(1);
    endfunction

endpackage

// ----- rtl/sgwl_in_stage.sv -----
module sgwl_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sgwl_pkg::op_t   operation,
    input  sgwl_pkg::addr_t address,
    input  logic            take,
    output logic            item_valid,
    output sgwl_pkg::op_t   item_op,
    output sgwl_pkg::addr_t item_address
);
    import sgwl_pkg::*;

    logic  valid_reg;
    op_t   op_reg;
    addr_t address_reg;

    assign in_ready     = !valid_reg || take;
    assign item_valid   = valid_reg;
    assign item_op      = op_reg;
    assign item_address = address_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg      <= operation;
            address_reg <= address;
        end
    end

endmodule

// ----- rtl/sgwl_xlate.sv -----
module sgwl_xlate (
    input  sgwl_pkg::op_t          op,
    input  sgwl_pkg::addr_t        address,
    input  sgwl_pkg::map_state_t   map,
    output sgwl_pkg::addr_t        result_address,
    output sgwl_pkg::xlate_flags_t flags
);
    import sgwl_pkg::*;

    line_t                      line;
    logic [LINE_BYTES_LOG2-1:0] off;
    count_t                     fwd_sum;
    count_t                     fwd_red;
    line_t                      fwd_mod;
    line_t                      fwd_phys;
    logic                       fwd_outside;
    logic                       rev_outside;
    logic                       rev_hit;
    line_t                      rev_base;
    line_t                      rev_diff;
    line_t                      rev_line;

    assign line = address[ADDR_BITS-1:LINE_BYTES_LOG2];
    assign off  = address[LINE_BYTES_LOG2-1:0];

    // forward: (line + start) mod n, then step over the gap
    assign fwd_sum     = {1'b0, line} + {1'b0, map.start};
    assign fwd_red     = (fwd_sum >= {1'b0, map.n}) ? fwd_sum - {1'b0, map.n} : fwd_sum;
    assign fwd_mod     = fwd_red[LINE_BITS-1:0];
    assign fwd_phys    = (fwd_mod >= map.gap) ? fwd_mod + line_t'(1) : fwd_mod;
    assign fwd_outside = line >= map.n;

    // reverse: undo the gap step, then (base - start) mod n
    assign rev_outside = {1'b0, line} >= map.line_count;
    assign rev_hit     = line == map.gap;

    always_comb
    begin
        if (rev_hit)
        begin
            rev_base = map.gap;
        end
        else if (line < map.gap)
        begin
            rev_base = line;
        end
        else
        begin
            rev_base = line - line_t'(1);
        end
        rev_diff = rev_base - map.start;
        if (rev_base >= map.start)
        begin
            rev_line = (rev_diff == map.n) ? '0 : rev_diff;
        end
        else
        begin
            rev_line = rev_diff + map.n;
        end
    end

    always_comb
    begin
        result_address = '0;
        flags          = '0;
        unique case (op)
            OP_FWD:
            begin
                flags.out_of_region  = fwd_outside;
                flags.boundary_alias = line == map.n;
                result_address       = fwd_outside ? address : {fwd_phys, off};
            end
            OP_REV:
            begin
                if (rev_outside)
                begin
                    result_address = address;
                end
                else
                begin
                    flags.gap_hit  = rev_hit;
                    result_address = {rev_line, off};
                end
            end
            default:
            begin
                result_address = '0;
            end
        endcase
    end

endmodule

// ----- rtl/sgwl_ctrl.sv -----
module sgwl_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  sgwl_pkg::cfg_idx_t     cfg_index,
    input  sgwl_pkg::cfg_data_t    cfg_data,
    input  logic                   fire,
    input  sgwl_pkg::op_t          op,
    input  sgwl_pkg::xlate_flags_t flags,
    output sgwl_pkg::map_state_t   map,
    output sgwl_pkg::totals_t      totals_next,
    output logic                   moved
);
    import sgwl_pkg::*;

    count_t    line_count_reg, line_count_next;
    interval_t interval_reg, interval_next;
    line_t     start_reg, start_next;
    line_t     gap_reg, gap_next;
    interval_t since_move_reg, since_move_next;
    totals_t   totals_reg;

    count_t    n_full;
    count_t    lines_clamped;
    count_t    clamped_less_one;
    interval_t since_inc;
    line_t     start_inc;
    logic      is_write;

    assign n_full    = line_count_reg - count_t'(1);
    assign map.line_count = line_count_reg;
    assign map.n     = n_full[LINE_BITS-1:0];
    assign map.start = start_reg;
    assign map.gap   = gap_reg;

    assign is_write  = fire && (op == OP_WRITE);
    assign since_inc = (&since_move_reg) ? since_move_reg : since_move_reg + interval_t'(1);
    assign moved     = is_write && (since_inc >= interval_reg);
    assign start_inc = start_reg + line_t'(1);

    always_comb
    begin
        if (cfg_data < LINES_MIN)
        begin
            lines_clamped = LINES_MIN;
        end
        else if (cfg_data > LINES_MAX)
        begin
            lines_clamped = LINES_MAX;
        end
        else
        begin
            lines_clamped = cfg_data;
        end
        clamped_less_one = lines_clamped - count_t'(1);
    end

    always_comb
    begin
        line_count_next = line_count_reg;
        interval_next   = interval_reg;
        start_next      = start_reg;
        gap_next        = gap_reg;
        since_move_next = since_move_reg;
        totals_next     = totals_reg;

        if (is_write)
        begin
            totals_next.writes = sat_inc(totals_reg.writes);
            since_move_next    = since_inc;
        end
        if (fire && (op == OP_FWD) && flags.out_of_region)
        begin
            totals_next.outside = sat_inc(totals_reg.outside);
        end
        if (fire && (op == OP_FWD) && flags.boundary_alias)
        begin
            totals_next.aliased = sat_inc(totals_reg.aliased);
        end
        if (moved)
        begin
            // gap at slot zero wraps to the top and the rotation advances
            if (gap_reg != '0)
            begin
                gap_next = gap_reg - line_t'(1);
            end
            else
            begin
                gap_next   = map.n;
                start_next = (start_inc >= map.n) ? '0 : start_inc;
            end
            since_move_next   = '0;
            totals_next.moves = sat_inc(totals_reg.moves);
        end

        if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_LINE_COUNT:
                begin
                    line_count_next = lines_clamped;
                    gap_next        = clamped_less_one[LINE_BITS-1:0];
                    start_next      = '0;
                end
                REG_MOVE_INTERVAL:
                begin
                    interval_next = cfg_data[INTERVAL_BITS-1:0];
                end
                default:
                begin
                    interval_next = interval_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= LINES_RESET;
            interval_reg   <= INTERVAL_RESET;
            start_reg      <= '0;
            gap_reg        <= LINE_BITS'(1);
            since_move_reg <= '0;
            totals_reg     <= '0;
        end
        else
        begin
            line_count_reg <= line_count_next;
            interval_reg   <= interval_next;
            start_reg      <= start_next;
            gap_reg        <= gap_next;
            since_move_reg <= since_move_next;
            totals_reg     <= totals_next;
        end
    end

endmodule

// ----- rtl/start_gap_wear_leveler_top.sv -----
// throughput: one item per cycle, limited only by out_ready back-pressure
// input register, then translate and counter update into the result register
// reset: start 0, gap 1 (two lines), move interval 100, all totals cleared
module start_gap_wear_leveler_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  sgwl_pkg::cfg_idx_t  cfg_index,
    input  sgwl_pkg::cfg_data_t cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  sgwl_pkg::op_t       operation,
    input  sgwl_pkg::addr_t     address,
    output logic                out_valid,
    input  logic                out_ready,
    output sgwl_pkg::addr_t     result_address,
    output logic                out_of_region,
    output logic                boundary_alias,
    output logic                gap_hit,
    output logic                gap_moved,
    output sgwl_pkg::total_t    move_total,
    output sgwl_pkg::total_t    write_total,
    output sgwl_pkg::total_t    out_of_region_total,
    output sgwl_pkg::total_t    alias_total
);
    import sgwl_pkg::*;

    logic         item_valid;
    op_t          item_op;
    addr_t        item_address;
    logic         fire;
    logic         out_free;
    map_state_t   map;
    xlate_flags_t flags;
    addr_t        xlate_address;
    totals_t      totals_next;
    logic         moved;

    logic         out_valid_reg;
    addr_t        result_reg;
    xlate_flags_t flags_reg;
    logic         moved_reg;
    totals_t      totals_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign fire     = item_valid && out_free;

    sgwl_in_stage u_in (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .address      (address),
        .take         (fire),
        .item_valid   (item_valid),
        .item_op      (item_op),
        .item_address (item_address)
    );

    sgwl_xlate u_xlate (
        .op             (item_op),
        .address        (item_address),
        .map            (map),
        .result_address (xlate_address),
        .flags          (flags)
    );

    sgwl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fire         (fire),
        .op           (item_op),
        .flags        (flags),
        .map          (map),
        .totals_next  (totals_next),
        .moved        (moved)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= xlate_address;
            flags_reg  <= flags;
            moved_reg  <= moved;
            totals_reg <= totals_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign result_address      = result_reg;
    assign out_of_region       = flags_reg.out_of_region;
    assign boundary_alias      = flags_reg.boundary_alias;
    assign gap_hit             = flags_reg.gap_hit;
    assign gap_moved           = moved_reg;
    assign move_total          = totals_reg.moves;
    assign write_total         = totals_reg.writes;
    assign out_of_region_total = totals_reg.outside;
    assign alias_total         = totals_reg.aliased;

endmodule

// ----- rtl/sgwl_checker.sv -----
module sgwl_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input sgwl_pkg::addr_t  result_address,
    input logic             out_of_region,
    input logic             boundary_alias,
    input logic             gap_hit,
    input logic             gap_moved,
    input sgwl_pkg::total_t move_total,
    input sgwl_pkg::total_t write_total
);
    import sgwl_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_address))
        else $error("result changed while stalled");

    // an alias is always an out-of-region forward, never a reverse or write
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && boundary_alias |-> out_of_region && !gap_hit && !gap_moved)
        else $error("alias flag without out-of-region");

    // a gap move is counted in the same result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gap_moved |-> move_total != '0 && write_total != '0)
        else $error("gap moved but totals are zero");

    // totals never go down from one result to the next
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && $past(out_valid) |->
            write_total >= $past(write_total) && move_total >= $past(move_total))
        else $error("total decreased");

endmodule

bind start_gap_wear_leveler_top sgwl_checker u_sgwl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_address (result_address),
    .out_of_region  (out_of_region),
    .boundary_alias (boundary_alias),
    .gap_hit        (gap_hit),
    .gap_moved      (gap_moved),
    .move_total     (move_total),
    .write_total    (write_total)
);

// ----- tb/sv/start_gap_wear_leveler_top_tb.sv -----
module start_gap_wear_leveler_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sgwl_pkg::*;

    localparam int  CLK_PERIOD     = 10;
    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  PHASES         = 12;
    localparam int  PHASE_ITEMS    = 100;
    localparam int  HOLD_CYCLES    = 300;
    localparam op_t OP_UNUSED      = 2'd3;

    typedef struct packed {
        addr_t  addr;
        logic   oor;
        logic   boundary;
        logic   hit;
        logic   moved;
        total_t moves;
        total_t writes;
        total_t outside;
        total_t aliased;
    } leveler_result_t;

    // shadow of the mapping registers and totals, advanced on every input transfer
    class leveler_scoreboard;
        count_t          lines;
        line_t           n;
        line_t           start;
        line_t           gap;
        interval_t       interval;
        interval_t       since_move;
        total_t          moves;
        total_t          writes;
        total_t          outside;
        total_t          aliased;
        leveler_result_t results_due[$];
        int              errors;
        int              results_seen;
        int              moves_seen;

        function new();
            interval     = INTERVAL_RESET;
            since_move   = '0;
            moves        = '0;
            writes       = '0;
            outside      = '0;
            aliased      = '0;
            errors       = 0;
            results_seen = 0;
            moves_seen   = 0;
            set_lines(LINES_RESET);
        endfunction

        function void set_lines(count_t v);
            if (v < LINES_MIN)
                v = LINES_MIN;
            if (v > LINES_MAX)
                v = LINES_MAX;
            lines = v;
            n     = line_t'(v - 1'b1);
            gap   = n;
            start = '0;
        endfunction

        function void configure(cfg_idx_t idx, cfg_data_t data);
            if (idx == REG_LINE_COUNT)
                set_lines(count_t'(data));
            else if (idx == REG_MOVE_INTERVAL)
                interval = data[INTERVAL_BITS-1:0];
        endfunction

        function total_t bump(total_t v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        function void note_request(op_t op, addr_t addr);
            line_t                      line;
            line_t                      base;
            logic [LINE_BYTES_LOG2-1:0] off;
            count_t                     acc;
            leveler_result_t            r;
            line = addr[ADDR_BITS-1:LINE_BYTES_LOG2];
            off  = addr[LINE_BYTES_LOG2-1:0];
            r    = '0;
            case (op)
                OP_FWD:
                begin
                    if (line >= n)
                    begin
                        r.oor   = 1'b1;
                        outside = bump(outside);
                        if (line == n)
                        begin
                            r.boundary = 1'b1;
                            aliased    = bump(aliased);
                        end
                        r.addr = addr;
                    end
                    else
                    begin
                        acc = count_t'(line) + count_t'(start);
                        if (acc >= count_t'(n))
                            acc = acc - count_t'(n);
                        // skip over the unused slot
                        if (acc >= count_t'(gap))
                            acc = acc + 1'b1;
                        r.addr = {acc[LINE_BITS-1:0], off};
                    end
                end
                OP_REV:
                begin
                    if (count_t'(line) >= lines)
                        r.addr = addr;
                    else if (line == gap)
                    begin
                        r.hit = 1'b1;
                        acc   = count_t'(gap) + count_t'(n) - count_t'(start);
                        if (acc >= count_t'(n))
                            acc = acc - count_t'(n);
                        if (acc >= count_t'(n))
                            acc = acc - count_t'(n);
                        r.addr = {acc[LINE_BITS-1:0], off};
                    end
                    else
                    begin
                        base = (line < gap) ? line : line - 1'b1;
                        acc  = count_t'(base) + count_t'(n) - count_t'(start);
                        if (acc >= count_t'(n))
                            acc = acc - count_t'(n);
                        r.addr = {acc[LINE_BITS-1:0], off};
                    end
                end
                OP_WRITE:
                begin
                    writes = bump(writes);
                    if (since_move != '1)
                        since_move = since_move + 1'b1;
                    if (since_move >= interval)
                    begin
                        if (gap != '0)
                            gap = gap - 1'b1;
                        else
                        begin
                            // full rotation: gap wraps to the top, start advances
                            gap = n;
                            if (count_t'(start) + 1'b1 >= count_t'(n))
                                start = '0;
                            else
                                start = start + 1'b1;
                        end
                        since_move = '0;
                        moves      = bump(moves);
                        r.moved    = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            r.moves   = moves;
            r.writes  = writes;
            r.outside = outside;
            r.aliased = aliased;
            results_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [47:0] want, logic [47:0] got);
            if (want !== got)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch on %s at result %0d: expected %h, got %h",
                             name, results_seen, want, got);
            end
        endfunction

        function void check_result(leveler_result_t got);
            leveler_result_t want;
            if (results_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result transfer with nothing outstanding: %h", got);
                return;
            end
            want = results_due.pop_front();
            results_seen++;
            if (want.moved)
                moves_seen++;
            compare_field("result_address", want.addr, got.addr);
            compare_field("out_of_region", want.oor, got.oor);
            compare_field("boundary_alias", want.boundary, got.boundary);
            compare_field("gap_hit", want.hit, got.hit);
            compare_field("gap_moved", want.moved, got.moved);
            compare_field("move_total", want.moves, got.moves);
            compare_field("write_total", want.writes, got.writes);
            compare_field("out_of_region_total", want.outside, got.outside);
            compare_field("alias_total", want.aliased, got.aliased);
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      cfg_write_en;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_data;
    logic      in_valid;
    logic      in_ready;
    op_t       operation;
    addr_t     address;
    logic      out_valid;
    logic      out_ready;
    addr_t     result_address;
    logic      out_of_region;
    logic      boundary_alias;
    logic      gap_hit;
    logic      gap_moved;
    total_t    move_total;
    total_t    write_total;
    total_t    out_of_region_total;
    total_t    alias_total;

    leveler_scoreboard sb;
    bit tx_steady;
    bit rx_steady;
    int hold_req;
    int rx_stall;
    int quiet;
    int sent;
    int cfg_writes;

    start_gap_wear_leveler_top DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write_en        (cfg_write_en),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .operation           (operation),
        .address             (address),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .result_address      (result_address),
        .out_of_region       (out_of_region),
        .boundary_alias      (boundary_alias),
        .gap_hit             (gap_hit),
        .gap_moved           (gap_moved),
        .move_total          (move_total),
        .write_total         (write_total),
        .out_of_region_total (out_of_region_total),
        .alias_total         (alias_total)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int idle_len(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic addr_t at_line(logic [63:0] line, logic [LINE_BYTES_LOG2-1:0] off);
        return {line[LINE_BITS-1:0], off};
    endfunction

    // lines biased into the region, onto the gap and onto the boundary
    function automatic addr_t pick_addr();
        logic [63:0] wide;
        logic [63:0] line;
        int          r;
        wide = {$urandom, $urandom};
        r    = $urandom_range(0, 99);
        if (r < 15)
            return addr_t'(wide);
        if (r < 35)
        begin
            case ($urandom_range(0, 3))
                0:       line = 64'(sb.n);
                1:       line = 64'(sb.gap);
                2:       line = 64'(sb.lines);
                default: line = '0;
            endcase
        end
        else
            line = wide % 64'(sb.lines);
        return at_line(line, LINE_BYTES_LOG2'($urandom));
    endfunction

    task automatic send_item(op_t op, addr_t addr);
        int gap_cycles;
        gap_cycles = idle_len(tx_steady);
        if (gap_cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_cycles) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        address   <= addr;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        sb.note_request(op, addr);
        sent++;
    endtask

    task automatic send_random();
        int  r;
        op_t op;
        r = $urandom_range(0, 99);
        if (r < 35)
            op = OP_FWD;
        else if (r < 65)
            op = OP_REV;
        else if (r < 95)
            op = OP_WRITE;
        else
            op = OP_UNUSED;
        send_item(op, pick_addr());
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sb.configure(idx, data);
        cfg_writes++;
    endtask

    // result side: check each transfer, then decide ready for the next cycle
    initial
    begin
        leveler_result_t got;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready === 1'b1)
            begin
                got.addr     = result_address;
                got.oor      = out_of_region;
                got.boundary = boundary_alias;
                got.hit      = gap_hit;
                got.moved    = gap_moved;
                got.moves    = move_total;
                got.writes   = write_total;
                got.outside  = out_of_region_total;
                got.aliased  = alias_total;
                sb.check_result(got);
            end
            if (hold_req > 0)
            begin
                rx_stall = hold_req;
                hold_req = 0;
            end
            if (rx_stall > 0)
            begin
                out_ready <= 1'b0;
                rx_stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                rx_stall = idle_len(rx_steady);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_ready === 1'b1) ||
            (out_valid === 1'b1 && out_ready === 1'b1))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: %0d cycles without a transfer, %0d results outstanding",
                     quiet, sb.pending());
            $display("start_gap_wear_leveler_top_tb: errors");
            $finish;
        end
    end

    initial
    begin
        cfg_data_t lc;
        cfg_data_t mi;
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = REG_LINE_COUNT;
        cfg_data     = '0;
        in_valid     = 1'b0;
        operation    = OP_FWD;
        address      = '0;
        out_ready    = 1'b0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        hold_req     = 0;
        rx_stall     = 0;
        quiet        = 0;
        sent         = 0;
        cfg_writes   = 0;
        sb           = new();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset mapping: two lines, gap on line 1
        send_item(OP_FWD, '0);
        send_item(OP_FWD, at_line(1, 6'h3F));
        send_item(OP_FWD, '1);
        send_item(OP_REV, at_line(1, 6'h15));
        send_item(OP_REV, at_line(0, 6'h2A));
        send_item(OP_REV, at_line(2, 6'h00));
        send_item(OP_REV, '1);
        send_item(OP_UNUSED, '1);
        send_item(OP_WRITE, '1);

        // move on every write, run the gap through a full rotation
        wait_idle();
        write_reg(REG_MOVE_INTERVAL, 1);
        write_reg(REG_LINE_COUNT, 5);
        repeat (6) send_item(OP_WRITE, '0);
        send_item(OP_FWD, at_line(0, 6'h01));
        send_item(OP_FWD, at_line(3, 6'h3F));
        send_item(OP_FWD, at_line(4, 6'h00));
        send_item(OP_REV, at_line(64'(sb.gap), 6'h07));
        send_item(OP_REV, at_line(4, 6'h09));
        send_item(OP_REV, at_line(5, 6'h00));
        send_item(OP_REV, at_line(0, 6'h00));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0:       lc = 2;
                1:       lc = 3;
                2:       lc = cfg_data_t'($urandom_range(4, 40));
                3:       lc = 0;
                4:       lc = 1;
                5:       lc = cfg_data_t'($urandom_range(5, 300));
                6:       lc = cfg_data_t'(LINES_MAX);
                7:       lc = '1;
                8:       lc = cfg_data_t'({$urandom, $urandom}) >> 1;
                9:       lc = cfg_data_t'(LINES_MAX) + 1'b1;
                10:      lc = 9;
                default: lc = cfg_data_t'($urandom_range(2, 20));
            endcase
            case (phase % 4)
                0:       mi = 0;
                1:       mi = 1;
                2:       mi = cfg_data_t'($urandom_range(2, 5));
                default: mi = (phase == 7) ? {11'($urandom), 32'hFFFF_FFFF} : 3;
            endcase
            write_reg(REG_LINE_COUNT, lc);
            // last phase keeps the interval count across a line count change
            if (phase != PHASES - 1)
                write_reg(REG_MOVE_INTERVAL, mi);
            tx_steady = (phase == 3 || phase == 8);
            rx_steady = tx_steady;
            if (phase == 5)
            begin
                // receiver stalls while the sender keeps offering back to back
                hold_req  = HOLD_CYCLES;
                tx_steady = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase == 5 && i == 40)
                    tx_steady = 1'b0;
                send_random();
            end
        end

        wait_idle();
        repeat (10) @(posedge clk);
        $display("covered %0d requests across %0d register writes,", sent, cfg_writes);
        $display("clamped line counts and interval extremes");
        $display("%0d results checked, %0d of them gap moves, %0d mismatches",
                 sb.results_seen, sb.moves_seen, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("start_gap_wear_leveler_top_tb: clean");
        else
            $display("start_gap_wear_leveler_top_tb: errors");
        $finish;
    end

endmodule

// ----- start_gap_wear_leveler_top.f -----
rtl/sgwl_pkg.sv
rtl/sgwl_in_stage.sv
rtl/sgwl_xlate.sv
rtl/sgwl_ctrl.sv
rtl/start_gap_wear_leveler_top.sv
rtl/sgwl_checker.sv
tb/sv/start_gap_wear_leveler_top_tb.sv
